// ----- hdl/rmq_pkg.sv -----
`default_nettype none
package rmq_pkg;

  // field width of every matrix element and quaternion component
  localparam int WORD_BITS     = 16;
  localparam int FRAC_BITS_DEF = 14;

  typedef enum logic [1:0] {
    BR_TRACE,
    BR_X,
    BR_Y,
    BR_Z
  } branch_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] x_axis_x;
    logic signed [WORD_BITS-1:0] x_axis_y;
    logic signed [WORD_BITS-1:0] x_axis_z;
    logic signed [WORD_BITS-1:0] y_axis_x;
    logic signed [WORD_BITS-1:0] y_axis_y;
    logic signed [WORD_BITS-1:0] y_axis_z;
    logic signed [WORD_BITS-1:0] z_axis_x;
    logic signed [WORD_BITS-1:0] z_axis_y;
    logic signed [WORD_BITS-1:0] z_axis_z;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] quat_x;
    logic signed [WORD_BITS-1:0] quat_y;
    logic signed [WORD_BITS-1:0] quat_z;
    logic signed [WORD_BITS-1:0] quat_w;
    branch_t                     branch_used;
    logic                        degenerate;
  } out_word_t;

  // branch and degenerate flag travelling along the pipeline
  typedef struct packed {
    branch_t branch;
    logic    degen;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hdl/rmq_front.sv -----
`default_nettype none
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  localparam int CALC_BITS =
    ((FRAC_BITS > rmq_pkg::WORD_BITS) ? FRAC_BITS : rmq_pkg::WORD_BITS) + 4,
  localparam int ARG_BITS = CALC_BITS - 1,
  localparam int D_BITS = rmq_pkg::WORD_BITS + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire rmq_pkg::in_word_t         in_data,
  output logic                           out_valid,
  output logic [ARG_BITS-1:0]            out_arg,
  output logic [2:0][D_BITS-1:0]         out_d,
  output rmq_pkg::ctl_t                  out_ctl
);
  import rmq_pkg::*;

  localparam int W = WORD_BITS;

  logic signed [CALC_BITS-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
  logic signed [CALC_BITS-1:0] one_c, trace, arg;
  logic signed [D_BITS-1:0]    a10, a20, a01, a21, a02, a12;
  logic [2:0][D_BITS-1:0]      d_sel;
  branch_t                     br;
  logic                        degen;

  logic                        valid_r;
  logic [ARG_BITS-1:0]         arg_r;
  logic [2:0][D_BITS-1:0]      d_r;
  ctl_t                        ctl_r;

  assign m00 = {{(CALC_BITS-W){in_data.x_axis_x[W-1]}}, in_data.x_axis_x};
  assign m10 = {{(CALC_BITS-W){in_data.x_axis_y[W-1]}}, in_data.x_axis_y};
  assign m20 = {{(CALC_BITS-W){in_data.x_axis_z[W-1]}}, in_data.x_axis_z};
  assign m01 = {{(CALC_BITS-W){in_data.y_axis_x[W-1]}}, in_data.y_axis_x};
  assign m11 = {{(CALC_BITS-W){in_data.y_axis_y[W-1]}}, in_data.y_axis_y};
  assign m21 = {{(CALC_BITS-W){in_data.y_axis_z[W-1]}}, in_data.y_axis_z};
  assign m02 = {{(CALC_BITS-W){in_data.z_axis_x[W-1]}}, in_data.z_axis_x};
  assign m12 = {{(CALC_BITS-W){in_data.z_axis_y[W-1]}}, in_data.z_axis_y};
  assign m22 = {{(CALC_BITS-W){in_data.z_axis_z[W-1]}}, in_data.z_axis_z};

  assign a10 = m10[D_BITS-1:0];
  assign a20 = m20[D_BITS-1:0];
  assign a01 = m01[D_BITS-1:0];
  assign a21 = m21[D_BITS-1:0];
  assign a02 = m02[D_BITS-1:0];
  assign a12 = m12[D_BITS-1:0];

  assign one_c = {{(CALC_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;
  assign trace = m00 + m11 + m22;

  always_comb begin
    if (!trace[CALC_BITS-1]) begin
      br       = BR_TRACE;
      arg      = trace + one_c;
      d_sel[0] = a21 - a12;
      d_sel[1] = a02 - a20;
      d_sel[2] = a10 - a01;
    end else if (m00 > m11 && m00 > m22) begin
      br       = BR_X;
      arg      = one_c + m00 - m11 - m22;
      d_sel[0] = a10 + a01;
      d_sel[1] = a02 + a20;
      d_sel[2] = a21 - a12;
    end else if (m11 > m22) begin
      br       = BR_Y;
      arg      = one_c + m11 - m00 - m22;
      d_sel[0] = a10 + a01;
      d_sel[1] = a21 + a12;
      d_sel[2] = a02 - a20;
    end else begin
      br       = BR_Z;
      arg      = one_c + m22 - m00 - m11;
      d_sel[0] = a02 + a20;
      d_sel[1] = a21 + a12;
      d_sel[2] = a10 - a01;
    end
  end

  assign degen = arg[CALC_BITS-1] || (arg == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // keep the root argument positive so the divider never sees zero
  always_ff @(posedge clk) begin
    arg_r        <= degen ? {{(ARG_BITS-1){1'b0}}, 1'b1} : arg[ARG_BITS-1:0];
    d_r          <= d_sel;
    ctl_r.branch <= br;
    ctl_r.degen  <= degen;
  end

  assign out_valid = valid_r;
  assign out_arg   = arg_r;
  assign out_d     = d_r;
  assign out_ctl   = ctl_r;

endmodule
`default_nettype wire

// ----- hdl/rmq_sqrt.sv -----
`default_nettype none
module rmq_sqrt #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int ARG_BITS  = 19,
  parameter int PAY_BITS  = 1,
  localparam int SB = (ARG_BITS + FRAC_BITS + 1) / 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [ARG_BITS-1:0] in_arg,
  input  wire logic [PAY_BITS-1:0] in_pay,
  output logic                     out_valid,
  output logic [SB:0]              out_root,
  output logic [PAY_BITS-1:0]      out_pay
);

  localparam int RWE = 2 * SB;

  logic [SB-1:0]       root_r [SB];
  logic [SB+1:0]       rem_r  [SB];
  logic [RWE-1:0]      rad_r  [SB];
  logic [PAY_BITS-1:0] pay_r  [SB];
  logic [SB-1:0]       vld_r;

  logic                valid_out_r;
  logic [SB:0]         root_out_r;
  logic [PAY_BITS-1:0] pay_out_r;

  genvar k;
  generate
    for (k = 0; k < SB; k++) begin : g_st
      logic [SB-1:0]       root_in;
      logic [SB+1:0]       rem_in, rem_sh, trial;
      logic [RWE-1:0]      rad_in;
      logic [PAY_BITS-1:0] pay_in;
      logic                vld_in, take;

      if (k == 0) begin : g_first
        assign root_in = '0;
        assign rem_in  = '0;
        assign rad_in  = {{(RWE-ARG_BITS){1'b0}}, in_arg} << FRAC_BITS;
        assign pay_in  = in_pay;
        assign vld_in  = in_valid;
      end else begin : g_next
        assign root_in = root_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign rad_in  = rad_r[k-1];
        assign pay_in  = pay_r[k-1];
        assign vld_in  = vld_r[k-1];
      end

      // bring down two radicand bits, try root*4+1
      assign rem_sh = {rem_in[SB-1:0], rad_in[RWE-1 -: 2]};
      assign trial  = {root_in, 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        root_r[k] <= {root_in[SB-2:0], take};
        rem_r[k]  <= take ? (rem_sh - trial) : rem_sh;
        rad_r[k]  <= rad_in << 2;
        pay_r[k]  <= pay_in;
      end
    end
  endgenerate

  // round to nearest: a remainder above the root rounds up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out_r <= 1'b0;
    end else begin
      valid_out_r <= vld_r[SB-1];
    end
  end

  always_ff @(posedge clk) begin
    root_out_r <= {1'b0, root_r[SB-1]} +
                  {{SB{1'b0}}, (rem_r[SB-1] > {2'b00, root_r[SB-1]})};
    pay_out_r  <= pay_r[SB-1];
  end

  assign out_valid = valid_out_r;
  assign out_root  = root_out_r;
  assign out_pay   = pay_out_r;

endmodule
`default_nettype wire

// ----- hdl/rmq_div.sv -----
`default_nettype none
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int S_BITS    = 18,
  parameter int D_BITS    = 17,
  parameter int NUM_BITS  = 31,
  parameter int PAY_BITS  = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [S_BITS-1:0]          in_s,
  input  wire logic [2:0][D_BITS-1:0]     in_d,
  input  wire logic [PAY_BITS-1:0]        in_pay,
  output logic                            out_valid,
  output logic [2:0][NUM_BITS-1:0]        out_q,
  output logic [2:0]                      out_neg,
  output logic [PAY_BITS-1:0]             out_pay
);

  localparam int VB = S_BITS + 1;
  localparam int NW = NUM_BITS;

  logic [VB-1:0]          div_r [NW];
  logic [2:0][NW-1:0]     num_r [NW];
  logic [2:0][VB:0]       rem_r [NW];
  logic [2:0][NW-1:0]     q_r   [NW];
  logic [2:0]             neg_r [NW];
  logic [PAY_BITS-1:0]    pay_r [NW];
  logic [NW-1:0]          vld_r;

  logic [2:0][NW-1:0]     num0;
  logic [2:0]             neg0;

  genvar k, l;
  generate
    // numerator |D| * 2^F + s, divisor 2s: rounds half away from zero
    for (l = 0; l < 3; l++) begin : g_init
      logic [D_BITS-1:0] mag;
      assign neg0[l]  = in_d[l][D_BITS-1];
      assign mag      = neg0[l] ? (~in_d[l] + 1'b1) : in_d[l];
      assign num0[l]  = ({{(NW-D_BITS){1'b0}}, mag} << FRAC_BITS) +
                        {{(NW-S_BITS){1'b0}}, in_s};
    end

    for (k = 0; k < NW; k++) begin : g_st
      logic [VB-1:0]       div_in;
      logic [2:0][NW-1:0]  num_in, q_in;
      logic [2:0][VB:0]    rem_in;
      logic [2:0]          neg_in;
      logic [PAY_BITS-1:0] pay_in;
      logic                vld_in;

      if (k == 0) begin : g_first
        assign div_in = {in_s, 1'b0};
        assign num_in = num0;
        assign q_in   = '0;
        assign rem_in = '0;
        assign neg_in = neg0;
        assign pay_in = in_pay;
        assign vld_in = in_valid;
      end else begin : g_next
        assign div_in = div_r[k-1];
        assign num_in = num_r[k-1];
        assign q_in   = q_r[k-1];
        assign rem_in = rem_r[k-1];
        assign neg_in = neg_r[k-1];
        assign pay_in = pay_r[k-1];
        assign vld_in = vld_r[k-1];
      end

      for (l = 0; l < 3; l++) begin : g_lane
        logic [VB:0] r2;
        logic        ge;
        assign r2 = {rem_in[l][VB-1:0], num_in[l][NW-1]};
        assign ge = r2 >= {1'b0, div_in};

        always_ff @(posedge clk) begin
          rem_r[k][l] <= ge ? (r2 - {1'b0, div_in}) : r2;
          num_r[k][l] <= num_in[l] << 1;
          q_r[k][l]   <= {q_in[l][NW-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        div_r[k] <= div_in;
        neg_r[k] <= neg_in;
        pay_r[k] <= pay_in;
      end
    end
  endgenerate

  assign out_valid = vld_r[NW-1];
  assign out_q     = q_r[NW-1];
  assign out_neg   = neg_r[NW-1];
  assign out_pay   = pay_r[NW-1];

endmodule
`default_nettype wire

// ----- hdl/rotation_matrix_to_quaternion_core.sv -----
`default_nettype none
// Rotation matrix to quaternion (Shepperd's method) in signed fixed point:
// a matrix word is taken at every clock edge where start is high, and busy
// is always low, so one matrix enters per cycle without a gap. Each result
// word appears on out_data for exactly one cycle with out_valid high. A
// matrix passes in order through the front register, the bit-serial
// square root (one root bit per stage; SB = (ARG_BITS + FRAC_BITS + 1) / 2
// is the root width), its rounding register, the restoring dividers (one
// quotient bit per stage; NW = 16 + FRAC_BITS + 1 is the quotient width)
// that it feeds, and then the output register. Results
// come out in input order and cannot be held off: the receiver must take
// every word in the cycle it is shown. A matrix whose root argument is zero
// or negative returns zeros with degenerate set and the branch still named.
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire rmq_pkg::in_word_t  in_data,
  output logic                    out_valid,
  output rmq_pkg::out_word_t      out_data
);
  import rmq_pkg::*;

  localparam int W         = WORD_BITS;
  localparam int CALC_BITS = ((FRAC_BITS > W) ? FRAC_BITS : W) + 4;
  localparam int ARG_BITS  = CALC_BITS - 1;
  localparam int SB        = (ARG_BITS + FRAC_BITS + 1) / 2;
  localparam int S_BITS    = SB + 1;
  localparam int D_BITS    = W + 1;
  localparam int NW        = W + FRAC_BITS + 1;
  localparam int PAY1      = 3 * D_BITS + $bits(ctl_t);
  localparam int PAY2      = S_BITS + $bits(ctl_t);

  // the pipeline never stalls
  assign busy = 1'b0;

  // front: trace, branch pick, root argument, off-diagonal pairs
  logic                    f_valid;
  logic [ARG_BITS-1:0]     f_arg;
  logic [2:0][D_BITS-1:0]  f_d;
  ctl_t                    f_ctl;

  rmq_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_arg   (f_arg),
    .out_d     (f_d),
    .out_ctl   (f_ctl)
  );

  // square root stages: carry pairs and control alongside
  logic                    r_valid;
  logic [S_BITS-1:0]       r_root;
  logic [PAY1-1:0]         r_pay;
  logic [2:0][D_BITS-1:0]  r_d;
  ctl_t                    r_ctl;

  rmq_sqrt #(
    .FRAC_BITS (FRAC_BITS),
    .ARG_BITS  (ARG_BITS),
    .PAY_BITS  (PAY1)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_arg    (f_arg),
    .in_pay    ({f_d, f_ctl}),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_pay   (r_pay)
  );

  assign {r_d, r_ctl} = r_pay;

  // three divider lanes share the root; carry root and control to the end
  logic                    q_valid;
  logic [2:0][NW-1:0]      q_mag;
  logic [2:0]              q_neg;
  logic [PAY2-1:0]         q_pay;
  logic [S_BITS-1:0]       q_root;
  ctl_t                    q_ctl;

  rmq_div #(
    .FRAC_BITS (FRAC_BITS),
    .S_BITS    (S_BITS),
    .D_BITS    (D_BITS),
    .NUM_BITS  (NW),
    .PAY_BITS  (PAY2)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_valid),
    .in_s      (r_root),
    .in_d      (r_d),
    .in_pay    ({r_root, r_ctl}),
    .out_valid (q_valid),
    .out_q     (q_mag),
    .out_neg   (q_neg),
    .out_pay   (q_pay)
  );

  assign {q_root, q_ctl} = q_pay;

  // clamp a magnitude to the signed word range and apply its sign
  function automatic logic [W-1:0] sat_fn(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] lim;
    logic [NW-1:0] qs;
    logic [NW-1:0] v;
    lim = {{(NW-1){1'b0}}, 1'b1} << (W - 1);
    if (!neg) begin
      lim = lim - 1'b1;
    end
    qs = (q > lim) ? lim : q;
    v  = neg ? (~qs + 1'b1) : qs;
    return v[W-1:0];
  endfunction

  logic [S_BITS:0]  lead_sum;
  logic [NW-1:0]    lead_mag;
  logic [W-1:0]     lead, c0, c1, c2;
  out_word_t        res_nxt;

  // leading component is s/2 rounded half up
  assign lead_sum = {1'b0, q_root} + {{S_BITS{1'b0}}, 1'b1};
  assign lead_mag = {{(NW-S_BITS){1'b0}}, lead_sum[S_BITS:1]};
  assign lead     = sat_fn(lead_mag, 1'b0);
  assign c0       = sat_fn(q_mag[0], q_neg[0]);
  assign c1       = sat_fn(q_mag[1], q_neg[1]);
  assign c2       = sat_fn(q_mag[2], q_neg[2]);

  // route lead and pair quotients to their components by branch
  always_comb begin
    res_nxt.branch_used = q_ctl.branch;
    res_nxt.degenerate  = q_ctl.degen;
    case (q_ctl.branch)
      BR_TRACE: begin
        res_nxt.quat_w = lead;
        res_nxt.quat_x = c0;
        res_nxt.quat_y = c1;
        res_nxt.quat_z = c2;
      end
      BR_X: begin
        res_nxt.quat_x = lead;
        res_nxt.quat_y = c0;
        res_nxt.quat_z = c1;
        res_nxt.quat_w = c2;
      end
      BR_Y: begin
        res_nxt.quat_y = lead;
        res_nxt.quat_x = c0;
        res_nxt.quat_z = c1;
        res_nxt.quat_w = c2;
      end
      BR_Z: begin
        res_nxt.quat_z = lead;
        res_nxt.quat_x = c0;
        res_nxt.quat_y = c1;
        res_nxt.quat_w = c2;
      end
      default: begin
        res_nxt.quat_w = '0;
        res_nxt.quat_x = '0;
        res_nxt.quat_y = '0;
        res_nxt.quat_z = '0;
      end
    endcase
    // drop the components of a degenerate matrix
    if (q_ctl.degen) begin
      res_nxt.quat_x = '0;
      res_nxt.quat_y = '0;
      res_nxt.quat_z = '0;
      res_nxt.quat_w = '0;
    end
  end

  // output register: each word is shown for one cycle
  logic       out_valid_r;
  out_word_t  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.quat_x == '0 && out_data.quat_y == '0 &&
      out_data.quat_z == '0 && out_data.quat_w == '0)
    else $error("degenerate word with nonzero components");

  a_degen_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.branch_used != BR_TRACE)
    else $error("trace branch flagged degenerate");

  a_lead_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate && out_data.branch_used == BR_TRACE |->
      !out_data.quat_w[W-1] && out_data.quat_w != '0)
    else $error("trace branch lead component not positive");

  a_lead_x_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate && out_data.branch_used == BR_X |->
      !out_data.quat_x[W-1] && out_data.quat_x != '0)
    else $error("x branch lead component not positive");
`endif

endmodule
`default_nettype wire
